[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked every cycle outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

[hw/rtl/stbt_pkg.sv]
// Package: constants and types for the sorted table budget trim block
package stbt_pkg;
    localparam int TS_W     = 32;
    localparam int SZ_W     = 20;
    localparam int TOT_W    = 25;
    localparam int CNT_W    = 6;
    localparam int DEPTH_DEFAULT = 32;
    localparam logic [TOT_W-1:0] BUDGET_RESET = 25'd512000;

    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_TRIM   = 2'd1;
    localparam logic [1:0] REQ_DUMP   = 2'd2;

    localparam logic [1:0] KIND_ACK   = 2'd0;
    localparam logic [1:0] KIND_EVICT = 2'd1;
    localparam logic [1:0] KIND_LIST  = 2'd2;
    localparam logic [1:0] KIND_DONE  = 2'd3;

    typedef struct packed {
        logic [1:0]      kind;
        logic [TS_W-1:0] ts;
        logic [SZ_W-1:0] sz;
        logic            status;
        logic            last;
    } t_result;
endpackage

[hw/rtl/stbt_store.sv]
// Entry memory: one write port, one registered read port
module stbt_store #(
    parameter int DEPTH = stbt_pkg::DEPTH_DEFAULT,
    parameter int AW    = 5
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [AW-1:0]                         i_waddr,
    input  logic [stbt_pkg::TS_W+stbt_pkg::SZ_W-1:0] i_wdata,
    input  logic [AW-1:0]                         i_raddr,
    output logic [stbt_pkg::TS_W+stbt_pkg::SZ_W-1:0] o_rdata
);
    import stbt_pkg::*;
    logic [TS_W+SZ_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hw/rtl/stbt_outreg.sv]
// Output register with valid/stall handshake
module stbt_outreg #(
    parameter int W = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_load,
    input  logic [W-1:0] i_data,
    input  logic         i_stall,
    output logic         o_valid,
    output logic         o_free,
    output logic [W-1:0] o_data
);
    logic r_valid;
    logic [W-1:0] r_data;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_data;
        end
    end
endmodule

[hw/rtl/sorted_table_budget_trim.sv]
// Top level: sorted table with budget trim
// Usage:
//  Input channel (i_valid/o_stall) takes one request: insert, trim or dump.
//  Output channel (o_valid/i_stall) gives the results of that request, the
//  final one flagged by o_last. Configuration: i_cfg_we writes the size
//  budget; the user must write it only while idle; the block does not check.
//  Entries live in one memory with a registered read. Each step reads
//  at most one entry a cycle and writes at most one a cycle.
//  Insert: a walk from the tail shifts later entries up one slot. Dump: a
//  read step and an emit step per entry, then a done marker. Trim: per
//  eviction, one scan of all entries to find the smallest, then a shift-down
//  walk of the tail.
//  One request is handled at a time; o_stall is high while busy.
//  Reset empties the table and total, and the budget returns to 512000.
//  A receiver stall holds the result register and the emit steps only.
module sorted_table_budget_trim #(
    parameter int TABLE_DEPTH = stbt_pkg::DEPTH_DEFAULT
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [1:0]                  i_req_type,
    input  logic [stbt_pkg::TS_W-1:0]   i_timestamp,
    input  logic [stbt_pkg::SZ_W-1:0]   i_entry_size,
    input  logic                        i_cfg_we,
    input  logic [stbt_pkg::TOT_W-1:0]  i_cfg_data,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [1:0]                  o_kind,
    output logic [stbt_pkg::TS_W-1:0]   o_out_timestamp,
    output logic [stbt_pkg::SZ_W-1:0]   o_out_size,
    output logic [stbt_pkg::TOT_W-1:0]  o_total_size,
    output logic [stbt_pkg::CNT_W-1:0]  o_entry_count,
    output logic                        o_status,
    output logic                        o_last
);
    import stbt_pkg::*;
    localparam int AW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW  = $clog2(TABLE_DEPTH + 1);
    localparam int XW  = SZ_W + CW;
    localparam int EW  = TS_W + SZ_W;
    localparam int OW  = $bits(t_result) + TOT_W + CNT_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_INS_RD = 4'd1;
    localparam logic [3:0] S_INS_CK = 4'd2;
    localparam logic [3:0] S_DMP_RD = 4'd3;
    localparam logic [3:0] S_DMP_EM = 4'd4;
    localparam logic [3:0] S_TR_CHK = 4'd5;
    localparam logic [3:0] S_TR_SCN = 4'd6;
    localparam logic [3:0] S_TR_EM  = 4'd7;
    localparam logic [3:0] S_TR_SH  = 4'd8;
    localparam logic [3:0] S_DONE   = 4'd9;
    localparam logic [3:0] S_ACK    = 4'd10;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [XW-1:0]     r_total, n_total;
    logic [TOT_W-1:0]  r_budget;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_min_idx, n_min_idx;
    logic [EW-1:0]     r_min_ent, n_min_ent;
    logic [TS_W-1:0]   r_ts, n_ts;
    logic [SZ_W-1:0]   r_sz, n_sz;
    logic              r_full, n_full;

    logic              mem_we;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [EW-1:0]     mem_wdata, mem_rdata;
    logic              out_load, out_free;
    t_result           res;
    logic [OW-1:0]     out_data;
    logic              acc;
    logic [TS_W-1:0]   rd_ts;
    logic [SZ_W-1:0]   rd_sz;
    logic [TOT_W-1:0]  tot_sat;

    assign rd_ts = mem_rdata[EW-1:SZ_W];
    assign rd_sz = mem_rdata[SZ_W-1:0];
    assign acc = i_valid && !o_stall;
    assign o_stall = (r_state != S_IDLE);

    stbt_store #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );

    always_comb begin
        n_state = r_state; n_count = r_count; n_total = r_total;
        n_idx = r_idx; n_min_idx = r_min_idx; n_min_ent = r_min_ent;
        n_ts = r_ts; n_sz = r_sz; n_full = r_full;
        mem_we = 1'b0; mem_waddr = '0; mem_wdata = '0; mem_raddr = '0;
        out_load = 1'b0;
        res = '0;
        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    n_ts = i_timestamp; n_sz = i_entry_size;
                    case (i_req_type)
                        REQ_INSERT: begin
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                n_full = 1'b1; n_state = S_ACK;
                            end else if (r_count == '0) begin
                                n_full = 1'b0; n_idx = '0; n_state = S_INS_CK;
                            end else begin
                                n_full = 1'b0; n_idx = r_count; n_state = S_INS_RD;
                            end
                        end
                        REQ_TRIM: n_state = S_TR_CHK;
                        REQ_DUMP: begin
                            n_idx = '0;
                            n_state = (r_count == '0) ? S_DONE : S_DMP_RD;
                        end
                        default: n_state = S_DONE;
                    endcase
                end
            end
            // walk down from the tail: read slot idx-1
            S_INS_RD: begin
                mem_raddr = AW'(r_idx - 1'b1);
                n_state = S_INS_CK;
            end
            S_INS_CK: begin
                // place at idx when slot idx-1 stays ahead of the new entry
                if (r_idx == '0 || (rd_ts < r_ts && r_idx != CW'(1))
                        || (r_idx == CW'(1) && !(r_ts < rd_ts))) begin
                    mem_we = 1'b1; mem_waddr = AW'(r_idx);
                    mem_wdata = {r_ts, r_sz};
                    n_count = r_count + 1'b1;
                    n_total = r_total + XW'(r_sz);
                    n_state = S_ACK;
                end else begin
                    mem_we = 1'b1; mem_waddr = AW'(r_idx); mem_wdata = mem_rdata;
                    n_idx = r_idx - 1'b1;
                    if (r_idx == CW'(1)) begin
                        n_state = S_INS_CK;
                    end else begin
                        mem_raddr = AW'(r_idx - 2'd2);
                        n_state = S_INS_CK;
                    end
                end
            end
            S_ACK: begin
                if (out_free) begin
                    res.kind = KIND_ACK; res.status = r_full; res.last = 1'b1;
                    out_load = 1'b1; n_state = S_IDLE;
                end
            end
            S_DMP_RD: begin
                mem_raddr = AW'(r_idx);
                n_state = S_DMP_EM;
            end
            S_DMP_EM: begin
                mem_raddr = AW'(r_idx);
                if (out_free) begin
                    res.kind = KIND_LIST; res.ts = rd_ts; res.sz = rd_sz;
                    out_load = 1'b1;
                    n_idx = r_idx + 1'b1;
                    n_state = (r_idx + 1'b1 == r_count) ? S_DONE : S_DMP_RD;
                end
            end
            S_TR_CHK: begin
                if (r_total > XW'(r_budget) && r_count != '0) begin
                    mem_raddr = '0; n_idx = '0; n_state = S_TR_SCN;
                end else begin
                    n_state = S_DONE;
                end
            end
            // data for slot idx arrives; next read idx+1
            S_TR_SCN: begin
                mem_raddr = AW'(r_idx + 1'b1);
                if (r_idx == '0 || rd_sz < r_min_ent[SZ_W-1:0]) begin
                    n_min_idx = r_idx; n_min_ent = mem_rdata;
                end
                n_idx = r_idx + 1'b1;
                if (r_idx + 1'b1 == r_count) n_state = S_TR_EM;
            end
            S_TR_EM: begin
                if (out_free) begin
                    n_count = r_count - 1'b1;
                    n_total = r_total - XW'(r_min_ent[SZ_W-1:0]);
                    res.kind = KIND_EVICT; res.ts = r_min_ent[EW-1:SZ_W];
                    res.sz = r_min_ent[SZ_W-1:0];
                    out_load = 1'b1;
                    n_idx = r_min_idx;
                    mem_raddr = AW'(r_min_idx + 1'b1);
                    n_state = (r_min_idx + 1'b1 >= r_count) ? S_TR_CHK : S_TR_SH;
                end
            end
            // rdata holds slot idx+1; move it to idx
            S_TR_SH: begin
                mem_we = 1'b1; mem_waddr = AW'(r_idx); mem_wdata = mem_rdata;
                mem_raddr = AW'(r_idx + 2'd2);
                n_idx = r_idx + 1'b1;
                if (r_idx + 2'd2 >= r_count + 1'b1) n_state = S_TR_CHK;
            end
            S_DONE: begin
                if (out_free) begin
                    res.kind = KIND_DONE; res.last = 1'b1;
                    out_load = 1'b1; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign tot_sat = (n_total > XW'({TOT_W{1'b1}})) ? {TOT_W{1'b1}} : TOT_W'(n_total);
    assign out_data = {res, tot_sat, CNT_W'(n_count)};

    stbt_outreg #(.W(OW)) u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(out_load), .i_data(out_data),
        .i_stall(i_stall), .o_valid(o_valid), .o_free(out_free),
        .o_data({o_kind, o_out_timestamp, o_out_size, o_status, o_last,
                 o_total_size, o_entry_count})
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_count <= '0; r_total <= '0; r_budget <= BUDGET_RESET;
        end else begin
            r_state <= n_state; r_count <= n_count; r_total <= n_total;
            if (i_cfg_we) r_budget <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_min_idx <= n_min_idx; r_min_ent <= n_min_ent;
        r_ts <= n_ts; r_sz <= n_sz; r_full <= n_full;
    end
endmodule

[hw/rtl/stbt_checker.sv]
// Port-level checker for the sorted table budget trim block
`include "assert_macros.svh"
module stbt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [1:0]  o_kind,
    input logic        o_last,
    input logic        o_status
);
    import stbt_pkg::*;
    `CHK_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_kind), "result dropped under stall")
    `CHK_IMPL(a_done_last, i_clk, i_rst_n, o_valid && o_kind == KIND_DONE, o_last, "done marker without last")
    `CHK_IMPL(a_status, i_clk, i_rst_n, o_valid && o_status, o_kind == KIND_ACK, "full status on non-ack")
    `CHK_IMPL(a_busy, i_clk, i_rst_n, o_valid && !o_last, o_stall, "input free mid request")
    `CHK_NEXT(a_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall, "not busy after accepted transaction")
endmodule

bind sorted_table_budget_trim stbt_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
    .o_valid(o_valid), .i_stall(i_stall), .o_kind(o_kind), .o_last(o_last),
    .o_status(o_status)
);
